/* design/dmc_pkg.sv */
// dmc_pkg: shared types and constants of the direct-mapped cache tag unit
// no dependencies; used by dmc_ctrl, dmc_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

  // cache geometry
  localparam int unsigned LINE_BYTES = 32;
  localparam int unsigned LINE_COUNT = 128;
  localparam int unsigned ADDR_W     = 32;

  localparam int unsigned OFFSET_W = $clog2(LINE_BYTES);
  localparam int unsigned INDEX_W  = $clog2(LINE_COUNT);
  localparam int unsigned BLOCK_W  = ADDR_W - OFFSET_W;
  localparam int unsigned TAG_W    = BLOCK_W - INDEX_W;
  localparam int unsigned BYTES_W  = 6;

  // packed result: 95 bits of fields, padded to whole bytes
  localparam int unsigned OUT_FIELDS_W = OFFSET_W + BLOCK_W + INDEX_W + TAG_W
                                       + 1 + 1 + BYTES_W + 1 + BYTES_W + 1 + TAG_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [BYTES_W-1:0] LINE_BYTES_CODE = BYTES_W'(LINE_BYTES);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } dmc_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // register the item and read the tag store
    logic commit;   // load the result and update the line
  } dmc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;   // result register holds an item
    logic out_taken;  // that item leaves this cycle
  } dmc_sts_t;

  typedef struct packed {
    logic [TAG_W-1:0]    evicted_tag;
    logic                replacement;
    logic [BYTES_W-1:0]  writeback_bytes;
    logic                writeback;
    logic [BYTES_W-1:0]  fill_bytes;
    logic                fill_read;
    logic                miss;
    logic [TAG_W-1:0]    tag_value;
    logic [INDEX_W-1:0]  line_index;
    logic [BLOCK_W-1:0]  block_number;
    logic [OFFSET_W-1:0] byte_offset;
  } dmc_result_t;

endpackage

`default_nettype wire

/* design/dmc_ctrl.sv */
// dmc_ctrl: two-state sequencer of the cache tag unit
// depends on dmc_pkg (state enum, command and status structs)
`timescale 1ns / 1ps
`default_nettype none

module dmc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dmc_pkg::dmc_sts_t sts_i,
  output dmc_pkg::dmc_cmd_t      cmd_o
);

  dmc_pkg::dmc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      dmc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = dmc_pkg::ST_LOOKUP;
        end
      end
      dmc_pkg::ST_LOOKUP: begin
        // wait while an earlier result is still held downstream
        if (!sts_i.out_full || sts_i.out_taken) begin
          cmd_o.commit = 1'b1;
          state_d      = dmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dmc_pkg::ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.capture && cmd_o.commit))
    else $error("capture and commit in the same cycle");

  a_commit_follows_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> $past(cmd_o.capture) || $past(state_q == dmc_pkg::ST_LOOKUP))
    else $error("commit without a captured item");

endmodule

`default_nettype wire

/* design/dmc_datapath.sv */
// dmc_datapath: address split, tag store, valid and dirty bits, result register
// depends on dmc_pkg (geometry constants, command/status/result structs)
`timescale 1ns / 1ps
`default_nettype none

module dmc_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dmc_pkg::dmc_cmd_t             cmd_i,
  output dmc_pkg::dmc_sts_t                  sts_o,
  input  wire logic [dmc_pkg::ADDR_W-1:0]    address_i,
  input  wire logic                          req_type_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output dmc_pkg::dmc_result_t               result_o
);

  localparam int unsigned IW = dmc_pkg::INDEX_W;
  localparam int unsigned TW = dmc_pkg::TAG_W;
  localparam int unsigned OW = dmc_pkg::OFFSET_W;

  logic [dmc_pkg::ADDR_W-1:0] addr_q;
  logic                       wr_q;
  logic [TW-1:0]              rd_tag_q;
  logic [TW-1:0]              tag_mem [dmc_pkg::LINE_COUNT];
  logic [dmc_pkg::LINE_COUNT-1:0] valid_q, dirty_q;
  logic                       out_valid_q;
  dmc_pkg::dmc_result_t       result_q, result_d;

  logic [IW-1:0] idx, in_idx;
  logic [TW-1:0] tag;
  logic          line_valid, hit, repl, wb;

  assign in_idx = address_i[OW +: IW];
  assign idx    = addr_q[OW +: IW];
  assign tag    = addr_q[OW + IW +: TW];

  // item register and registered tag store read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q   <= address_i;
      wr_q     <= req_type_i;
      rd_tag_q <= tag_mem[in_idx];
    end
    if (cmd_i.commit) begin
      tag_mem[idx] <= tag;
    end
  end

  assign line_valid = valid_q[idx];
  assign hit        = line_valid && (rd_tag_q == tag);
  assign repl       = line_valid && (rd_tag_q != tag);
  assign wb         = repl && dirty_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q[idx] <= 1'b1;
      dirty_q[idx] <= wr_q || (hit && dirty_q[idx]);
    end
  end

  always_comb begin
    result_d.byte_offset     = addr_q[OW-1:0];
    result_d.block_number    = addr_q[dmc_pkg::ADDR_W-1:OW];
    result_d.line_index      = idx;
    result_d.tag_value       = tag;
    result_d.miss            = !hit;
    result_d.fill_read       = !hit;
    result_d.fill_bytes      = hit ? '0 : dmc_pkg::LINE_BYTES_CODE;
    result_d.writeback       = wb;
    result_d.writeback_bytes = wb ? dmc_pkg::LINE_BYTES_CODE : '0;
    result_d.replacement     = repl;
    result_d.evicted_tag     = repl ? rd_tag_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_o        = result_q;
  assign sts_o.out_full  = out_valid_q;
  assign sts_o.out_taken = out_valid_q && out_ready_i;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !out_valid_q || out_ready_i)
    else $error("pending result overwritten");

  a_line_valid_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> valid_q[$past(idx)])
    else $error("line not valid after update");

  a_wb_needs_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !result_q.writeback || (result_q.replacement && result_q.miss))
    else $error("write-back without replacement");

endmodule

`default_nettype wire

/* design/direct_mapped_writeback_cache_tags_unit.sv */
// direct_mapped_writeback_cache_tags_unit: tag store of a direct-mapped,
// write-back, write-allocate cache; top level joining dmc_ctrl and dmc_datapath
// depends on dmc_pkg, dmc_ctrl, dmc_datapath
//
//  channel  | direction | tdata                          | tuser
//  ---------+-----------+--------------------------------+---------
//  s_axis   | in        | address [31:0]                 | req_type
//  m_axis   | out       | result fields, 96 bits (below) | -
//
// order: an accepted item is registered with its tag memory read, then committed
// to the result register; the unit then returns to idle, so one item is in flight
// at a time and a new item is accepted only once the last one has been committed
// reset: valid and dirty bits clear at once, no clearing pass; tag memory
// contents only matter once the valid bit of a line is set
// stalls: the result register holds an item while the next one is accepted and
// looked up; the lookup waits only if that earlier result is still not taken
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_writeback_cache_tags_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // slave side
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [dmc_pkg::ADDR_W-1:0]       s_axis_tdata_i,  // address
  input  wire logic                             s_axis_tuser_i,  // req_type
  // master side
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // byte_offset [4:0], block_number [31:5], line_index [38:32],
  // tag_value [58:39], miss [59], fill_read [60], fill_bytes [66:61],
  // writeback [67], writeback_bytes [73:68], replacement [74],
  // evicted_tag [94:75], zero pad [95]
  output logic [dmc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o
);

  dmc_pkg::dmc_cmd_t    cmd;
  dmc_pkg::dmc_sts_t    sts;
  dmc_pkg::dmc_result_t result;

  // sequencer: idle takes an item, lookup commits it once the result slot frees
  dmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tag memory, line state bits and the result register
  dmc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .address_i   (s_axis_tdata_i),
    .req_type_i  (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result)
  );

  // the result struct is declared last field first, so it packs lowest-first
  assign m_axis_tdata_o = {(dmc_pkg::OUT_TDATA_W - dmc_pkg::OUT_FIELDS_W)'(0), result};

endmodule

`default_nettype wire
